FILE: hdl/wto_pkg.sv
`default_nettype none

package wto_pkg;

  // input beat modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_AT    = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // interpolation fraction taken from just below the binary point
  localparam int FRAC_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RD1,
    ST_RD2,
    ST_DIFF,
    ST_OUT
  } wto_state_t;

  typedef struct packed {
    logic load_v1;
    logic load_prod;
  } interp_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/wto_in_if.sv
`default_nettype none

interface wto_in_if #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [PHASE_BITS-1:0]         tuning_word;
  logic [PHASE_BITS-1:0]         phase_value;
  logic [IDX_W-1:0]              entry_index;
  logic signed [SAMPLE_BITS-1:0] entry_value;

  modport source (
    output valid, mode, tuning_word, phase_value, entry_index, entry_value,
    input  ready
  );

  modport sink (
    input  valid, mode, tuning_word, phase_value, entry_index, entry_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/wto_out_if.sv
`default_nettype none

interface wto_out_if #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16
);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [IDX_W-1:0]              table_position;

  modport source (
    output valid, sample, table_position,
    input  ready
  );

  modport sink (
    input  valid, sample, table_position,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/wavetable_oscillator.sv
// a sample beat passes through MUL, RD1, RD2, DIFF and OUT (multiply, two reads of
//   the single-port table, interpolation multiply); OUT loads the output once it is free
// new beats are taken only in IDLE; write and phase reset beats leave it in IDLE
// reset: phase accumulator 0, table_length TABLE_DEPTH, output empty;
//   table contents are undefined until written
`default_nettype none

module wavetable_oscillator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int LEN_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata,
  wto_in_if.sink                in_if,
  wto_out_if.source             out_if
);

  localparam int PROD_W = PHASE_BITS + LEN_W;

  wto_pkg::wto_state_t state_r, state_nxt;

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [PHASE_BITS-1:0]  acc_r, acc_nxt;
  logic [PHASE_BITS-1:0]  ph_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [IDX_W-1:0]       out_pos_r;

  logic                   in_acc;
  logic                   is_sample;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W:0]         idx_inc;
  logic [IDX_W-1:0]       idx2;
  logic [wto_pkg::FRAC_BITS-1:0] frac;

  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_addr;
  logic [SAMPLE_BITS-1:0] tbl_rd;
  wto_pkg::interp_ctl_t   ictl;
  logic                   out_load;
  logic                   in_ready;
  logic signed [SAMPLE_BITS-1:0] interp_sample;

  assign in_acc    = in_if.valid && in_ready;
  assign is_sample = (in_if.mode == wto_pkg::MODE_NEXT) || (in_if.mode == wto_pkg::MODE_AT);

  // effective length: zero acts as one, anything past the table as the table depth
  always_comb begin
    if (cfg_wdata == '0) begin
      len_nxt = LEN_W'(1);
    end else if (cfg_wdata > LEN_W'(TABLE_DEPTH)) begin
      len_nxt = LEN_W'(TABLE_DEPTH);
    end else begin
      len_nxt = cfg_wdata;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (in_acc && (in_if.mode == wto_pkg::MODE_NEXT)) begin
      acc_nxt = acc_r + in_if.tuning_word;
    end else if (in_acc && (in_if.mode == wto_pkg::MODE_CLEAR)) begin
      acc_nxt = '0;
    end
  end

  assign idx     = prod_r[PHASE_BITS +: IDX_W];
  assign frac    = prod_r[PHASE_BITS-1 -: wto_pkg::FRAC_BITS];
  assign idx_inc = {1'b0, idx} + (IDX_W+1)'(1);
  assign idx2    = (idx_inc == (IDX_W+1)'(len_r)) ? '0 : idx_inc[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wto_pkg::ST_IDLE: begin
        if (in_acc && is_sample) begin
          state_nxt = wto_pkg::ST_MUL;
        end
      end
      wto_pkg::ST_MUL:  state_nxt = wto_pkg::ST_RD1;
      wto_pkg::ST_RD1:  state_nxt = wto_pkg::ST_RD2;
      wto_pkg::ST_RD2:  state_nxt = wto_pkg::ST_DIFF;
      wto_pkg::ST_DIFF: state_nxt = wto_pkg::ST_OUT;
      wto_pkg::ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = wto_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wto_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready          = 1'b0;
    tbl_we            = 1'b0;
    tbl_addr          = idx;
    ictl.load_v1      = 1'b0;
    ictl.load_prod    = 1'b0;
    out_load          = 1'b0;
    case (state_r)
      wto_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        tbl_addr = in_if.entry_index;
        tbl_we   = in_if.valid && (in_if.mode == wto_pkg::MODE_WRITE)
                   && ({1'b0, in_if.entry_index} < (IDX_W+1)'(TABLE_DEPTH));
      end
      wto_pkg::ST_RD1:  tbl_addr = idx;
      wto_pkg::ST_RD2: begin
        tbl_addr     = idx2;
        ictl.load_v1 = 1'b1;
      end
      wto_pkg::ST_DIFF: ictl.load_prod = 1'b1;
      wto_pkg::ST_OUT:  out_load = !out_valid_r || out_if.ready;
      default: tbl_addr = idx;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wto_pkg::ST_IDLE;
      len_r       <= LEN_W'(TABLE_DEPTH);
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      // next sample uses the phase from before the advance
      ph_r <= (in_if.mode == wto_pkg::MODE_NEXT) ? acc_r : in_if.phase_value;
    end
    if (state_r == wto_pkg::ST_MUL) begin
      prod_r <= PROD_W'(ph_r) * PROD_W'(len_r);
    end
    if (out_load) begin
      out_sample_r <= interp_sample;
      out_pos_r    <= idx;
    end
  end

  wto_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (SAMPLE_BITS)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .addr    (tbl_addr),
    .wdata   (in_if.entry_value),
    .rd_data (tbl_rd)
  );

  wto_interp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp (
    .clk     (clk),
    .ctl     (ictl),
    .rd_data (tbl_rd),
    .frac    (frac),
    .sample  (interp_sample)
  );

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_r;
  assign out_if.sample         = out_sample_r;
  assign out_if.table_position = out_pos_r;

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_sample) |=> (state_r == wto_pkg::ST_MUL))
    else $error("sample beat did not start the multiply");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == wto_pkg::ST_OUT) && (!out_valid_r || out_if.ready)) |=> out_valid_r)
    else $error("finished sample not presented");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(acc_r))
    else $error("phase accumulator moved without an input beat");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (in_acc && (state_r == wto_pkg::ST_IDLE)))
    else $error("table written outside an accepted write beat");

  a_out_only_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == wto_pkg::ST_OUT))
    else $error("output raised outside the final step");

endmodule

`default_nettype wire

FILE: hdl/wto_table.sv
`default_nettype none

module wto_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/wto_interp.sv
`default_nettype none

module wto_interp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire wto_pkg::interp_ctl_t             ctl,
  input  wire logic [SAMPLE_BITS-1:0]           rd_data,
  input  wire logic [wto_pkg::FRAC_BITS-1:0]    frac,
  output logic signed [SAMPLE_BITS-1:0]         sample
);

  localparam int PW = SAMPLE_BITS + wto_pkg::FRAC_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] v1_r;
  logic signed [PW-1:0]          p_r;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [wto_pkg::FRAC_BITS:0] frac_s;
  logic signed [PW-1:0]          p_nxt;
  logic signed [PW-1:0]          step;

  assign diff   = $signed({rd_data[SAMPLE_BITS-1], rd_data})
                - $signed({v1_r[SAMPLE_BITS-1], v1_r});
  assign frac_s = $signed({1'b0, frac});
  assign p_nxt  = PW'(diff) * PW'(frac_s);

  always_ff @(posedge clk) begin
    if (ctl.load_v1) begin
      v1_r <= $signed(rd_data);
    end
    if (ctl.load_prod) begin
      p_r <= p_nxt;
    end
  end

  // arithmetic shift floors the step; result stays between the two entries
  assign step   = p_r >>> wto_pkg::FRAC_BITS;
  assign sample = v1_r + step[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire
